>>> rtl/lrb_pkg.sv
// Shared types and constants of the line ring buffer.
// Holds command codes, register indexes, byte and reset constants, the
// state type, the controller-to-datapath command struct and the datapath-to-controller status struct.
package lrb_pkg;

	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;

	localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
	localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;
	localparam logic [1:0] CFG_READY_CHAR   = 2'd2;

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [7:0] ZERO_BYTE    = 8'd0;

	localparam logic [3:0] ROW_COUNT_RESET    = 4'd8;
	localparam logic [6:0] COLUMN_COUNT_RESET = 7'd64;
	localparam logic [7:0] READY_CHAR_RESET   = 8'd0;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_WR2   = 5'b00100,
		ST_READ  = 5'b01000,
		ST_DONE  = 5'b10000
	} lrb_state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic wr2;
		logic rd_issue;
		logic done;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic newline;
	} dp_stat_t;

endpackage

>>> rtl/lrb_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing; the address width follows from DEPTH.
module lrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> rtl/lrb_ctrl.sv
// Controller state machine of the line ring buffer.
// Depends on lrb_pkg for the state type and the command and status structs.
module lrb_ctrl import lrb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd,
	output logic      busy
);

	lrb_state_t state_q;
	lrb_state_t state_d;
	logic       accept;

	assign busy   = !(state_q == ST_IDLE || state_q == ST_DONE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE, ST_DONE: begin
				if (accept) begin
					state_d = stat.newline ? ST_WR2 : ST_READ;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WR2:  state_d = ST_READ;
			ST_READ: state_d = ST_DONE;
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd.clear    = (state_q == ST_CLEAR);
		cmd.accept   = accept;
		cmd.wr2      = (state_q == ST_WR2);
		cmd.rd_issue = (state_q == ST_READ);
		cmd.done     = (state_q == ST_DONE);
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> !cmd.done)
		else $error("result strobe held for two cycles");

	a_plain_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !stat.newline) |-> ##2 cmd.done)
		else $error("result of a plain command not delivered after two cycles");

	a_newline_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && stat.newline) |-> ##3 cmd.done)
		else $error("result of a newline write not delivered after three cycles");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> (busy && !cmd.accept))
		else $error("command accepted during the clearing pass");

endmodule

>>> rtl/lrb_dp.sv
// Datapath of the line ring buffer: configuration registers, head and tail
// indices, the line store RAM and the result registers.
// Depends on lrb_pkg and lrb_ram.
module lrb_dp import lrb_pkg::*; #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	output dp_stat_t   stat,
	input  logic [1:0] command,
	input  logic [7:0] data_byte,
	input  logic [5:0] read_column,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output logic [7:0] head_char,
	output logic       tail_ready,
	output logic       release_blocked,
	output logic [7:0] read_char
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = $clog2(MAX_COLS);
	localparam int RNW   = ($clog2(MAX_ROWS + 1) > 4) ? $clog2(MAX_ROWS + 1) : 4;
	localparam int CNW   = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;

	logic [3:0]     row_count_q;
	logic [6:0]     column_count_q;
	logic [7:0]     ready_char_q;
	logic [RW-1:0]  hr_q;
	logic [CW-1:0]  hc_q;
	logic [RW-1:0]  tl_q;
	logic [AW-1:0]  clr_q;
	logic [1:0]     cmd_q;
	logic           rok_q;
	logic           blk_q;
	logic [7:0]     rd_q;

	logic [RNW-1:0] rows_used;
	logic [CNW-1:0] cols_used;
	logic [RW-1:0]  hr_adv;
	logic [CW-1:0]  hc_adv;
	logic [RW-1:0]  hr_nl;
	logic [RW-1:0]  tl_next;
	logic           rok;
	logic           we;
	logic [AW-1:0]  waddr;
	logic [7:0]     wdata;
	logic [AW-1:0]  raddr_a;
	logic [AW-1:0]  raddr_b;
	logic [7:0]     rdata_a;
	logic [7:0]     rdata_b;

	function automatic logic [RW-1:0] next_row(input logic [RW-1:0] r,
		input logic [RNW-1:0] lim);
		logic [RNW-1:0] inc;
		inc = RNW'(r) + RNW'(1);
		return (inc >= lim) ? '0 : RW'(inc);
	endfunction

	function automatic logic [AW-1:0] slot_addr(input logic [RW-1:0] r,
		input logic [CW-1:0] c);
		logic [AW:0] a;
		a = (AW+1)'(r) * (AW+1)'(MAX_COLS) + (AW+1)'(c);
		return AW'(a);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= ROW_COUNT_RESET;
			column_count_q <= COLUMN_COUNT_RESET;
			ready_char_q   <= READY_CHAR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROW_COUNT:    row_count_q    <= cfg_data[3:0];
				CFG_COLUMN_COUNT: column_count_q <= cfg_data[6:0];
				CFG_READY_CHAR:   ready_char_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (row_count_q == 4'd0) begin
			rows_used = RNW'(1);
		end else if (RNW'(row_count_q) > RNW'(MAX_ROWS)) begin
			rows_used = RNW'(MAX_ROWS);
		end else begin
			rows_used = RNW'(row_count_q);
		end
		if (column_count_q == 7'd0) begin
			cols_used = CNW'(1);
		end else if (CNW'(column_count_q) > CNW'(MAX_COLS)) begin
			cols_used = CNW'(MAX_COLS);
		end else begin
			cols_used = CNW'(column_count_q);
		end
	end

	// One byte stored at the head moves it one column, wrapping into the next row.
	always_comb begin
		if (CNW'(hc_q) + CNW'(1) >= cols_used) begin
			hc_adv = '0;
			hr_adv = next_row(hr_q, rows_used);
		end else begin
			hc_adv = CW'(CNW'(hc_q) + CNW'(1));
			hr_adv = hr_q;
		end
		hr_nl   = next_row(hr_adv, rows_used);
		tl_next = next_row(tl_q, rows_used);
		rok     = CNW'(read_column) < cols_used;
	end

	assign stat.clear_last = (clr_q == AW'(DEPTH - 1));
	assign stat.newline    = (command == CMD_WRITE) && (data_byte == NEWLINE_BYTE);

	always_comb begin
		we    = cmd.clear || cmd.wr2 ||
			(cmd.accept && (command == CMD_WRITE || command == CMD_RELEASE));
		waddr = slot_addr(hr_q, hc_q);
		wdata = ZERO_BYTE;
		if (cmd.clear) begin
			waddr = clr_q;
		end else if (cmd.accept && command == CMD_RELEASE) begin
			waddr = slot_addr(tl_q, '0);
		end else if (cmd.accept && command == CMD_WRITE) begin
			wdata = data_byte;
		end
		raddr_a = cmd.rd_issue ? slot_addr(hr_q, hc_q) : slot_addr(tl_q, CW'(read_column));
		raddr_b = slot_addr(tl_q, '0);
	end

	lrb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hr_q  <= '0;
			hc_q  <= '0;
			tl_q  <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.accept && command == CMD_WRITE) begin
				hr_q <= hr_adv;
				hc_q <= hc_adv;
			end
			if (cmd.accept && command == CMD_RELEASE && tl_next != hr_q) begin
				tl_q <= tl_next;
			end
			if (cmd.wr2) begin
				hc_q <= '0;
				hr_q <= (hr_nl == tl_q) ? hr_adv : hr_nl;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q <= command;
			rok_q <= rok;
			blk_q <= (command == CMD_RELEASE) && (tl_next == hr_q);
		end
		if (cmd.rd_issue) begin
			rd_q <= (cmd_q == CMD_READ && rok_q) ? rdata_a : ZERO_BYTE;
		end
	end

	assign head_char       = rdata_a;
	assign tail_ready      = (rdata_b == ready_char_q);
	assign release_blocked = blk_q;
	assign read_char       = rd_q;

endmodule

>>> rtl/line_ring_buffer.sv
// Top level of the line ring buffer: a ring of fixed-length line slots.
// Depends on lrb_pkg, lrb_ctrl and lrb_dp.
//
// Commands enter on start/command/data_byte/read_column and are taken at a
// clock edge where start is high and busy is low. Each command gives one
// result beat on head_char/tail_ready/release_blocked/read_char, marked by a
// one-cycle done strobe; the receiver has to take it in that cycle.
// Configuration registers (row_count, column_count, ready_char) are written
// on cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high and writes belong in idle periods.
// After the accept cycle the controller passes through READ and then DONE,
// where done rises; a newline write first passes through WR2 for a second
// store write of its zero byte. Busy drops again in the done cycle, so a new
// command can be accepted there. The line store is a RAM with one write port
// and two registered read ports, so the zero byte needs its own write state.
// After reset the controller sweeps all MAX_ROWS * MAX_COLS entries (512 by
// default) of the store to zero, one entry per cycle, with busy high.
module line_ring_buffer import lrb_pkg::*; #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [7:0] data_byte,
	input  logic [5:0] read_column,
	output logic       done,
	output logic [7:0] head_char,
	output logic       tail_ready,
	output logic       release_blocked,
	output logic [7:0] read_char,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;
	assign done      = cmd.done;

	lrb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	lrb_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.command         (command),
		.data_byte       (data_byte),
		.read_column     (read_column),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.head_char       (head_char),
		.tail_ready      (tail_ready),
		.release_blocked (release_blocked),
		.read_char       (read_char)
	);

endmodule
